>>> hw/rtl/pfm_pkg.sv
// ----------------------------------------------------------------------------
// pfm_pkg
// Shared types and constants for the page-frame matrix LRU table.
// ----------------------------------------------------------------------------
package pfm_pkg;

  // configuration register
  localparam int unsigned CFG_W = 4;
  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 4'd8;

  // width of the slot field in the response word
  localparam int unsigned SLOT_FIELD_W = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } pfm_state_e;

endpackage

>>> hw/rtl/pfm_if.sv
// ----------------------------------------------------------------------------
// pfm_if
// Valid/ready channels for page requests and lookup responses.
// ----------------------------------------------------------------------------
interface pfm_req_if #(
  parameter int unsigned KEY_BITS = 10
) ();
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] page_key;

  modport source (output valid, output page_key, input ready);
  modport sink   (input valid, input page_key, output ready);
endinterface

interface pfm_rsp_if #(
  parameter int unsigned KEY_BITS = 10
) ();
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic [pfm_pkg::SLOT_FIELD_W-1:0]  slot;
  logic                              evicted;
  logic [KEY_BITS-1:0]               evicted_key;

  modport source (output valid, output hit, output slot, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input slot, input evicted,
                  input evicted_key, output ready);
endinterface

>>> hw/rtl/pfm_key_mem.sv
// ----------------------------------------------------------------------------
// pfm_key_mem
// Page key store, one key per slot. One write port, one registered read port.
// ----------------------------------------------------------------------------
module pfm_key_mem #(
  parameter int unsigned SLOTS    = 8,
  parameter int unsigned KEY_BITS = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(SLOTS)-1:0] waddr_i,
  input  logic [KEY_BITS-1:0]      wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(SLOTS)-1:0] raddr_i,
  output logic [KEY_BITS-1:0]      rdata_o
);

  logic [KEY_BITS-1:0] mem [SLOTS];
  logic [KEY_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/pfm_lru_mem.sv
// ----------------------------------------------------------------------------
// pfm_lru_mem
// LRU matrix store, one row per word. Rows never written read as zeros.
// ----------------------------------------------------------------------------
module pfm_lru_mem #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(SLOTS)-1:0] waddr_i,
  input  logic [SLOTS-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(SLOTS)-1:0] raddr_i,
  output logic [SLOTS-1:0]         rdata_o
);

  logic [SLOTS-1:0] mem [SLOTS];
  logic [SLOTS-1:0] rdata_q;
  logic [SLOTS-1:0] row_vld_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (we_i) begin
        row_vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= row_vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rdata_q : '0;

endmodule

>>> hw/rtl/pfm_ctrl.sv
// ----------------------------------------------------------------------------
// pfm_ctrl
// Access sequencer: walks the slots to search keys and rank rows, picks the
// slot, then walks the matrix again to apply the touch. Holds the response.
// ----------------------------------------------------------------------------
module pfm_ctrl #(
  parameter int unsigned SLOTS    = 8,
  parameter int unsigned KEY_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [pfm_pkg::CFG_W-1:0]         slots_in_use_i,
  pfm_req_if.sink                           req_i,
  pfm_rsp_if.source                         rsp_o,
  // key store
  output logic                              key_we_o,
  output logic [$clog2(SLOTS)-1:0]          key_waddr_o,
  output logic [KEY_BITS-1:0]               key_wdata_o,
  output logic                              key_re_o,
  output logic [$clog2(SLOTS)-1:0]          key_raddr_o,
  input  logic [KEY_BITS-1:0]               key_rdata_i,
  // matrix store
  output logic                              lru_we_o,
  output logic [$clog2(SLOTS)-1:0]          lru_waddr_o,
  output logic [SLOTS-1:0]                  lru_wdata_o,
  output logic                              lru_re_o,
  output logic [$clog2(SLOTS)-1:0]          lru_raddr_o,
  input  logic [SLOTS-1:0]                  lru_rdata_i
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  pfm_pkg::pfm_state_e state_q, state_d;

  logic [CW-1:0]       rd_cnt_q;
  logic                cmp_vld_q;
  logic [SW-1:0]       cmp_idx_q;
  logic [KEY_BITS-1:0] key_q;
  logic [CW-1:0]       n_q;
  logic [CW-1:0]       valid_q;
  logic [SLOTS-1:0]    mask_q;
  logic [CW-1:0]       fill_q;
  logic                hit_q;
  logic [SW-1:0]       hit_idx_q;
  logic [SW-1:0]       best_idx_q;
  logic [CW-1:0]       best_ones_q;
  logic [KEY_BITS-1:0] best_key_q;
  logic [SW-1:0]       slot_q;
  logic                evict_q;

  logic                              out_vld_q;
  logic                              out_hit_q;
  logic [pfm_pkg::SLOT_FIELD_W-1:0]  out_slot_q;
  logic                              out_evict_q;
  logic [KEY_BITS-1:0]               out_ekey_q;

  logic [CW-1:0]    n_cfg;
  logic [SLOTS-1:0] mask_cfg;
  logic             rd_more;
  logic             free_slot;
  logic [SW-1:0]    slot_sel;
  logic [CW-1:0]    row_ones;
  logic             out_free;
  logic             accept;
  logic             rd_en;
  logic [SLOTS-1:0] row_new;

  // active slot count, clamped to 1..SLOTS
  always_comb begin
    if (slots_in_use_i == '0) begin
      n_cfg = CW'(1);
    end else if (32'(slots_in_use_i) > SLOTS) begin
      n_cfg = CW'(SLOTS);
    end else begin
      n_cfg = CW'(slots_in_use_i);
    end
    for (int j = 0; j < SLOTS; j++) begin
      mask_cfg[j] = (32'(j) < 32'(n_cfg));
    end
  end

  assign rd_more   = rd_cnt_q < n_q;
  assign free_slot = fill_q < n_q;
  assign slot_sel  = hit_q ? hit_idx_q : (free_slot ? fill_q[SW-1:0] : best_idx_q);
  assign row_ones  = CW'($countones(lru_rdata_i & mask_q));
  assign out_free  = !out_vld_q || rsp_o.ready;
  assign accept    = req_i.valid && req_i.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfm_pkg::ST_IDLE: begin
        if (req_i.valid) state_d = pfm_pkg::ST_SEARCH;
      end
      pfm_pkg::ST_SEARCH: begin
        if (!rd_more) state_d = pfm_pkg::ST_DECIDE;
      end
      pfm_pkg::ST_DECIDE: begin
        state_d = pfm_pkg::ST_UPDATE;
      end
      pfm_pkg::ST_UPDATE: begin
        if (!rd_more) state_d = pfm_pkg::ST_DONE;
      end
      pfm_pkg::ST_DONE: begin
        if (out_free) state_d = pfm_pkg::ST_IDLE;
      end
      default: state_d = pfm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready = 1'b0;
    rd_en       = 1'b0;
    key_we_o    = 1'b0;
    lru_we_o    = 1'b0;
    unique case (state_q)
      pfm_pkg::ST_IDLE:   req_i.ready = 1'b1;
      pfm_pkg::ST_SEARCH: rd_en = rd_more;
      pfm_pkg::ST_DECIDE: key_we_o = !hit_q;
      pfm_pkg::ST_UPDATE: begin
        rd_en    = rd_more;
        lru_we_o = cmp_vld_q;
      end
      pfm_pkg::ST_DONE:   ;
      default:            ;
    endcase
  end

  // touch: row of the chosen slot goes to ones, then its column to zeros
  always_comb begin
    row_new = lru_rdata_i;
    if (cmp_idx_q == slot_q) begin
      row_new = row_new | mask_q;
    end
    row_new[slot_q] = 1'b0;
  end

  assign key_re_o    = rd_en && (state_q == pfm_pkg::ST_SEARCH);
  assign key_raddr_o = rd_cnt_q[SW-1:0];
  assign key_waddr_o = slot_sel;
  assign key_wdata_o = key_q;
  assign lru_re_o    = rd_en;
  assign lru_raddr_o = rd_cnt_q[SW-1:0];
  assign lru_waddr_o = cmp_idx_q;
  assign lru_wdata_o = row_new;

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.slot        = out_slot_q;
  assign rsp_o.evicted     = out_evict_q;
  assign rsp_o.evicted_key = out_ekey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pfm_pkg::ST_IDLE;
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
      fill_q    <= '0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= rd_en;
      if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + CW'(1);
      end
      if (accept) begin
        rd_cnt_q <= '0;
        hit_q    <= 1'b0;
      end
      // key compare over the filled slots only, first match wins
      if (state_q == pfm_pkg::ST_SEARCH && cmp_vld_q && !hit_q &&
          CW'(cmp_idx_q) < valid_q && key_rdata_i == key_q) begin
        hit_q <= 1'b1;
      end
      if (state_q == pfm_pkg::ST_DECIDE) begin
        rd_cnt_q <= '0;
        if (!hit_q && free_slot) begin
          fill_q <= fill_q + CW'(1);
        end
      end
      if (state_q == pfm_pkg::ST_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      cmp_idx_q <= rd_cnt_q[SW-1:0];
    end
    if (accept) begin
      key_q   <= req_i.page_key;
      n_q     <= n_cfg;
      mask_q  <= mask_cfg;
      valid_q <= (fill_q < n_cfg) ? fill_q : n_cfg;
    end
    if (state_q == pfm_pkg::ST_SEARCH && cmp_vld_q) begin
      if (!hit_q && CW'(cmp_idx_q) < valid_q && key_rdata_i == key_q) begin
        hit_idx_q <= cmp_idx_q;
      end
      // most zeros in the active part of a row == fewest ones
      if (cmp_idx_q == '0 || row_ones < best_ones_q) begin
        best_idx_q  <= cmp_idx_q;
        best_ones_q <= row_ones;
        best_key_q  <= key_rdata_i;
      end
    end
    if (state_q == pfm_pkg::ST_DECIDE) begin
      slot_q  <= slot_sel;
      evict_q <= !hit_q && !free_slot;
    end
    if (state_q == pfm_pkg::ST_DONE && out_free) begin
      out_hit_q   <= hit_q;
      out_slot_q  <= pfm_pkg::SLOT_FIELD_W'(slot_q);
      out_evict_q <= evict_q;
      out_ekey_q  <= evict_q ? best_key_q : '0;
    end
  end

endmodule

>>> hw/rtl/page_frame_matrix_lru.sv
// ----------------------------------------------------------------------------
// page_frame_matrix_lru
// Fully associative page-frame table with matrix LRU replacement.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      word
//  req_i     in   valid/ready    page_key
//  rsp_o     out  valid/ready    hit, slot, evicted, evicted_key
//  cfg       in   cfg_we_i       cfg_data_i -> slots_in_use
//
// A response is built in two passes over the N active slots per accepted word:
// one pass over the key and matrix stores to search and rank rows, one pass
// over the matrix store to apply the touch, both limited by the single
// matrix read port. A new word is taken only once the access before it is done.
// Reset clears the matrix to zeros (per-row valid bits) and the fill count.
// The response sits in an output register; a new word is taken while it waits,
// and that access then holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module page_frame_matrix_lru #(
  parameter int unsigned SLOTS    = 8,
  parameter int unsigned KEY_BITS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  pfm_req_if.sink                   req_i,
  pfm_rsp_if.source                 rsp_o,
  input  logic                      cfg_we_i,
  input  logic [pfm_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int unsigned SW = $clog2(SLOTS);

  logic [pfm_pkg::CFG_W-1:0] slots_in_use_q;

  logic                key_we;
  logic [SW-1:0]       key_waddr;
  logic [KEY_BITS-1:0] key_wdata;
  logic                key_re;
  logic [SW-1:0]       key_raddr;
  logic [KEY_BITS-1:0] key_rdata;

  logic                lru_we;
  logic [SW-1:0]       lru_waddr;
  logic [SLOTS-1:0]    lru_wdata;
  logic                lru_re;
  logic [SW-1:0]       lru_raddr;
  logic [SLOTS-1:0]    lru_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q <= pfm_pkg::SLOTS_IN_USE_RST;
    end else if (cfg_we_i) begin
      slots_in_use_q <= cfg_data_i;
    end
  end

  pfm_key_mem #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_key_mem (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  pfm_lru_mem #(
    .SLOTS (SLOTS)
  ) u_lru_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (lru_we),
    .waddr_i (lru_waddr),
    .wdata_i (lru_wdata),
    .re_i    (lru_re),
    .raddr_i (lru_raddr),
    .rdata_o (lru_rdata)
  );

  pfm_ctrl #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .slots_in_use_i (slots_in_use_q),
    .req_i          (req_i),
    .rsp_o          (rsp_o),
    .key_we_o       (key_we),
    .key_waddr_o    (key_waddr),
    .key_wdata_o    (key_wdata),
    .key_re_o       (key_re),
    .key_raddr_o    (key_raddr),
    .key_rdata_i    (key_rdata),
    .lru_we_o       (lru_we),
    .lru_waddr_o    (lru_waddr),
    .lru_wdata_o    (lru_wdata),
    .lru_re_o       (lru_re),
    .lru_raddr_o    (lru_raddr),
    .lru_rdata_i    (lru_rdata)
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page-frame matrix LRU table. A directed
// sequence walks fill, hit, eviction and table-size corner cases, then
// random page streams run under a series of table sizes. Every response
// word is checked against an in-bench model of the frame table and matrix.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned SLOTS      = 8;
  localparam int unsigned KEY_BITS   = 10;
  localparam int unsigned MAX_IDLE   = 11;
  localparam int unsigned ITEM_LAT   = 2 * SLOTS + 4;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 113;

  typedef struct packed {
    logic                               hit;
    logic [pfm_pkg::SLOT_FIELD_W-1:0]   slot;
    logic                               evicted;
    logic [KEY_BITS-1:0]                evicted_key;
  } lookup_t;

  // Frame table model plus the queue of lookups still owed by the block.
  class lru_scoreboard;
    logic [KEY_BITS-1:0]       frame_key [SLOTS];
    logic [SLOTS-1:0]          age_row [SLOTS];
    int unsigned               filled;
    logic [pfm_pkg::CFG_W-1:0] frames_cfg;
    lookup_t                   owed_q[$];
    int unsigned               errors;
    int unsigned               accesses;
    int unsigned               hits;
    int unsigned               evictions;

    function new();
      frames_cfg = pfm_pkg::SLOTS_IN_USE_RST;
      filled     = 0;
      errors     = 0;
      accesses   = 0;
      hits       = 0;
      evictions  = 0;
      for (int i = 0; i < SLOTS; i++) begin
        frame_key[i] = '0;
        age_row[i]   = '0;
      end
    endfunction

    function void set_frames(logic [pfm_pkg::CFG_W-1:0] value);
      frames_cfg = value;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void note_request(logic [KEY_BITS-1:0] key);
      int unsigned n;
      int unsigned searched;
      int unsigned zeros;
      int unsigned best_zeros;
      int unsigned s;
      lookup_t     res;
      n = (frames_cfg < 1) ? 1 : ((frames_cfg > SLOTS) ? SLOTS : frames_cfg);
      searched = (filled < n) ? filled : n;
      res = '0;
      s = 0;
      for (int i = 0; i < searched; i++) begin
        if (!res.hit && frame_key[i] == key) begin
          res.hit = 1'b1;
          s = i;
        end
      end
      if (!res.hit) begin
        if (filled < n) begin
          s = filled;
          filled++;
        end else begin
          // oldest frame: row with the most zeros, lowest index wins ties
          best_zeros = 0;
          for (int i = 0; i < n; i++) begin
            zeros = 0;
            for (int j = 0; j < n; j++) if (!age_row[i][j]) zeros++;
            if (i == 0 || zeros > best_zeros) begin
              best_zeros = zeros;
              s = i;
            end
          end
          res.evicted     = 1'b1;
          res.evicted_key = frame_key[s];
        end
        frame_key[s] = key;
      end
      for (int j = 0; j < n; j++) age_row[s][j] = 1'b1;
      for (int i = 0; i < n; i++) age_row[i][s] = 1'b0;
      res.slot = s[pfm_pkg::SLOT_FIELD_W-1:0];
      owed_q.push_back(res);
      accesses++;
      if (res.hit) hits++;
      if (res.evicted) evictions++;
    endfunction

    function void check_response(lookup_t got);
      lookup_t want;
      if (owed_q.size() == 0) begin
        $error("response word with nothing outstanding: hit=%0d slot=%0d", got.hit, got.slot);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, got.slot);
        errors++;
      end
      if (got.evicted !== want.evicted) begin
        $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
        errors++;
      end
      if (got.evicted_key !== want.evicted_key) begin
        $error("evicted_key: expected %0d, got %0d", want.evicted_key, got.evicted_key);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [pfm_pkg::CFG_W-1:0] cfg_data_i;

  pfm_req_if #(.KEY_BITS(KEY_BITS)) req_if ();
  pfm_rsp_if #(.KEY_BITS(KEY_BITS)) rsp_if ();

  page_frame_matrix_lru #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  lru_scoreboard scoreboard;
  bit            send_idle;
  bit            recv_idle;
  int unsigned   send_gap;
  int unsigned   size_changes;
  int unsigned   cycle_count;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // a held valid drops only when the next word is not sent back to back
  task automatic send_page(input logic [KEY_BITS-1:0] key);
    repeat (send_gap) @(posedge clk_i);
    req_if.valid    <= 1'b1;
    req_if.page_key <= key;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    scoreboard.note_request(key);
    send_gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (send_gap > 0) req_if.valid <= 1'b0;
  endtask

  task automatic stop_sending();
    if (send_gap == 0) req_if.valid <= 1'b0;
    send_gap = 1;
  endtask

  task automatic drain_table();
    stop_sending();
    while (scoreboard.pending() != 0) @(posedge clk_i);
    repeat (ITEM_LAT) @(posedge clk_i);
  endtask

  task automatic write_frames(input logic [pfm_pkg::CFG_W-1:0] value);
    drain_table();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scoreboard.set_frames(value);
    size_changes++;
  endtask

  task automatic send_keys(input logic [pfm_pkg::CFG_W-1:0] frames,
                           input logic [KEY_BITS-1:0] keys[$]);
    write_frames(frames);
    foreach (keys[i]) send_page(keys[i]);
  endtask

  // random page stream: mostly a small working set so hits and evictions mix
  task automatic random_phase(input logic [pfm_pkg::CFG_W-1:0] frames,
                              input int unsigned count, input bit pause_midway);
    logic [KEY_BITS-1:0] pool[$];
    int unsigned         pool_size;
    logic [KEY_BITS-1:0] key;
    write_frames(frames);
    pool_size = $urandom_range(2, SLOTS + 4);
    pool.delete();
    for (int i = 0; i < pool_size; i++) begin
      pool.push_back(KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1)));
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) key = KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
      else key = pool[$urandom_range(0, pool_size - 1)];
      send_page(key);
      if (pause_midway && i == count / 2) drain_table();
    end
  endtask

  // response side: random back-pressure per word
  initial begin
    int unsigned stall;
    lookup_t     got;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(rsp_if.valid && rsp_if.ready)) @(posedge clk_i);
      got.hit         = rsp_if.hit;
      got.slot        = rsp_if.slot;
      got.evicted     = rsp_if.evicted;
      got.evicted_key = rsp_if.evicted_key;
      scoreboard.check_response(got);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("run stopped at cycle limit with %0d words outstanding", scoreboard.pending());
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [pfm_pkg::CFG_W-1:0] sizes[10];
    scoreboard   = new();
    size_changes = 0;
    send_gap     = 0;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_data_i      <= '0;
    req_if.valid    <= 1'b0;
    req_if.page_key <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // two frames, then grow: fill resumes from the fill point
    send_keys(4'd2, '{10'd0, 10'd1023, 10'd0, 10'd341, 10'd1023});
    send_keys(4'd8, '{10'd682, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd341, 10'd0});
    // shrunk below the fill point, zero acts as one, above range clamps
    send_keys(4'd1, '{10'd100, 10'd100, 10'd200});
    send_keys(4'd0, '{10'd200, 10'd300});
    send_keys(4'd15, '{10'd1023, 10'd300, 10'd7});

    sizes = '{4'd15, 4'd3, 4'd5, 4'd8, 4'd4, 4'd0, 4'd6, 4'd7, 4'd1, 4'd8};
    for (int p = 0; p < 10; p++) begin
      send_idle = (p % 3) != 1;
      recv_idle = (p % 4) != 2;
      random_phase(sizes[p], PHASE_ITEMS, p == 4);
    end

    send_idle = 1'b1;
    recv_idle = 1'b1;
    drain_table();
    $display("%0d page accesses over %0d table sizes: %0d hits, %0d evictions",
             scoreboard.accesses, size_changes, scoreboard.hits, scoreboard.evictions);
    if (scoreboard.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", scoreboard.errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/pfm_pkg.sv
hw/rtl/pfm_if.sv
hw/rtl/pfm_key_mem.sv
hw/rtl/pfm_lru_mem.sv
hw/rtl/pfm_ctrl.sv
hw/rtl/page_frame_matrix_lru.sv
bench/tb_top.sv
